// ----- hdl/alpo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// alpo_pkg: shared types and constants for the position-addressed list
// Request, response and cell command types, op and status codes.
// ---------------------------------------------------------------------------
package alpo_pkg;

   localparam int CAPACITY = 128;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int POS_W    = 8;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_INSERT = 2'd1,
      OP_APPEND = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   pos;
      logic signed [31:0] item;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      status_type         status;
      logic [7:0]         count;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   typedef struct packed {
      logic               shift_up;
      logic               shift_down;
      logic               rd_load;
      logic [IDX_W-1:0]   pos;
      logic signed [31:0] item;
   } cmd_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] value;
   } car_type;

endpackage
`default_nettype wire

// ----- hdl/alpo_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// alpo_cell: one list entry cell
// Holds one entry, shifts with its neighbors on insert and delete, and
// passes a read carrier toward cell zero.
// ---------------------------------------------------------------------------
module alpo_cell
   import alpo_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [IDX_W-1:0]   cell_idx,
   input  wire cmd_type            cmd,
   input  wire logic signed [31:0] lower_entry,
   input  wire logic signed [31:0] upper_entry,
   input  wire car_type            upper_car,
   output      logic signed [31:0] entry_q,
   output      car_type            car_q
);

   logic signed [31:0] entry_ff, entry_in;
   logic               carv_ff, carv_in;
   logic signed [31:0] carval_ff, carval_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift_up) begin
         if (cell_idx == cmd.pos) begin
            entry_in = cmd.item;
         end else if (cell_idx > cmd.pos) begin
            entry_in = lower_entry;
         end
      end else if (cmd.shift_down) begin
         if (cell_idx >= cmd.pos) begin
            entry_in = upper_entry;
         end
      end
      if (cmd.rd_load) begin
         carv_in   = (cell_idx == cmd.pos);
         carval_in = entry_ff;
      end else begin
         carv_in   = upper_car.valid;
         carval_in = upper_car.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      carval_ff <= carval_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carv_ff <= 1'b0;
      end else begin
         carv_ff <= carv_in;
      end
   end

   assign entry_q     = entry_ff;
   assign car_q.valid = carv_ff;
   assign car_q.value = carval_ff;

endmodule
`default_nettype wire

// ----- hdl/array_list_position_ops_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// array_list_position_ops_core: ordered list with positional access
// Each request is taken when start is high and busy is low; its result is
// shown on rsp_data for exactly one cycle with rsp_strobe high, and the
// receiver cannot stall it. Insert, append, delete and failed requests
// strobe their result in the cycle after acceptance, and a new request may
// be taken in that same cycle. A successful read at position p keeps busy
// high while the entry walks down the carrier chain of the cell row to cell
// zero; its result strobes, and busy falls, once the entry reaches cell zero.
// Entries never written read as undefined.
// ---------------------------------------------------------------------------
module array_list_position_ops_core
   import alpo_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_data,
   output      logic    rsp_strobe,
   output      rsp_type rsp_data
);

   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_READ = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               strobe_ff, strobe_in;
   logic signed [31:0] value_ff, value_in;
   status_type         status_ff, status_in;

   cmd_type            cmd;
   logic               take;
   logic               full;
   logic [CMP_W-1:0]   pos_wide;
   logic [CMP_W-1:0]   cnt_wide;
   logic [CMP_W-1:0]   cnt_out;

   logic signed [31:0] entry_q [CAPACITY];
   car_type            car_q   [CAPACITY];

   assign take     = start && (state_ff == STATE_IDLE);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign pos_wide = CMP_W'(req_data.pos);
   assign cnt_wide = CMP_W'(count_ff);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      strobe_in  = 1'b0;
      value_in   = value_ff;
      status_in  = status_ff;
      cmd        = '0;
      cmd.item   = req_data.item;
      cmd.pos    = IDX_W'(pos_wide);
      unique case (state_ff)
         STATE_IDLE: begin
            if (take) begin
               value_in  = '0;
               status_in = STATUS_OK;
               unique case (req_data.op)
                  OP_READ: begin
                     if (pos_wide < cnt_wide) begin
                        cmd.rd_load = 1'b1;
                        state_in    = STATE_READ;
                     end else begin
                        status_in = STATUS_BADPOS;
                        strobe_in = 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     strobe_in = 1'b1;
                     if (pos_wide > cnt_wide) begin
                        status_in = STATUS_BADPOS;
                     end else if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cmd.shift_up = 1'b1;
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  OP_APPEND: begin
                     strobe_in = 1'b1;
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cmd.shift_up = 1'b1;
                        cmd.pos      = IDX_W'(cnt_wide);
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     strobe_in = 1'b1;
                     if (pos_wide < cnt_wide) begin
                        cmd.shift_down = 1'b1;
                        count_in       = count_ff - 1'b1;
                     end else begin
                        status_in = STATUS_BADPOS;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                     status_in = STATUS_BADPOS;
                  end
               endcase
            end
         end
         STATE_READ: begin
            if (car_q[0].valid) begin
               value_in  = car_q[0].value;
               strobe_in = 1'b1;
               state_in  = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= STATE_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] lower_entry;
      logic signed [31:0] upper_entry;
      car_type            upper_car;

      if (i == 0) begin : g_first
         assign lower_entry = '0;
      end else begin : g_mid_lo
         assign lower_entry = entry_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign upper_entry = '0;
         assign upper_car   = '0;
      end else begin : g_mid_hi
         assign upper_entry = entry_q[i+1];
         assign upper_car   = car_q[i+1];
      end

      alpo_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(i)),
         .cmd         (cmd),
         .lower_entry (lower_entry),
         .upper_entry (upper_entry),
         .upper_car   (upper_car),
         .entry_q     (entry_q[i]),
         .car_q       (car_q[i])
      );
   end

   assign cnt_out = CMP_W'(count_ff);

   assign busy                = (state_ff != STATE_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_data.value      = value_ff;
   assign rsp_data.status     = status_ff;
   assign rsp_data.count      = cnt_out[7:0];
   assign rsp_data.is_empty   = (count_ff == '0);
   assign rsp_data.is_full    = (count_ff == CNT_W'(CAPACITY));

endmodule
`default_nettype wire

// ----- sim/alpo_list_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alpo_list_checker: result checker for the position-addressed list
// Watches the request and result channels of the list core. Each accepted
// request runs through a shadow copy of the list, and the predicted result
// is queued. Each strobed result is compared field by field with the oldest
// queued one. Exports the mismatch count, the number of results still
// owed, and the shadow entry count so that the stimulus can aim positions.
// ---------------------------------------------------------------------------
module alpo_list_checker
   import alpo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   input  logic    run_done,
   output int      fail_count,
   output int      pending_results,
   output int      entry_total
);

   logic signed [31:0] shadow_cells [CAPACITY];
   rsp_type            owed_rsp_q [$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // apply one request to the shadow list and return its result
   function automatic rsp_type predict_list_op(input req_type r);
      rsp_type res;
      int      k;
      res        = '0;
      res.status = STATUS_OK;
      case (r.op)
         OP_READ: begin
            if (r.pos < entry_total) res.value = shadow_cells[r.pos];
            else res.status = STATUS_BADPOS;
         end
         OP_INSERT: begin
            if (r.pos > entry_total) res.status = STATUS_BADPOS;
            else if (entry_total >= CAPACITY) res.status = STATUS_FULL;
            else begin
               for (k = entry_total; k > r.pos; k--) shadow_cells[k] = shadow_cells[k-1];
               shadow_cells[r.pos] = r.item;
               entry_total++;
            end
         end
         OP_APPEND: begin
            if (entry_total >= CAPACITY) res.status = STATUS_FULL;
            else begin
               shadow_cells[entry_total] = r.item;
               entry_total++;
            end
         end
         default: begin
            if (r.pos < entry_total) begin
               for (k = r.pos; k + 1 < entry_total; k++) shadow_cells[k] = shadow_cells[k+1];
               entry_total--;
            end else res.status = STATUS_BADPOS;
         end
      endcase
      res.count    = 8'(entry_total);
      res.is_empty = (entry_total == 0);
      res.is_full  = (entry_total == CAPACITY);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         owed_rsp_q.delete();
         entry_total = 0;
         fail_count  = 0;
      end else begin
         if (rsp_strobe) begin
            if (owed_rsp_q.size() == 0) begin
               report_mismatch("result strobed with no request outstanding");
            end else begin
               want = owed_rsp_q.pop_front();
               if (rsp_data.value !== want.value)
                  report_mismatch($sformatf("value got %0d want %0d",
                                            rsp_data.value, want.value));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.count !== want.count)
                  report_mismatch($sformatf("count got %0d want %0d",
                                            rsp_data.count, want.count));
               if (rsp_data.is_empty !== want.is_empty)
                  report_mismatch($sformatf("is_empty got %b want %b",
                                            rsp_data.is_empty, want.is_empty));
               if (rsp_data.is_full !== want.is_full)
                  report_mismatch($sformatf("is_full got %b want %b",
                                            rsp_data.is_full, want.is_full));
            end
         end
         if (start && !busy) owed_rsp_q.push_back(predict_list_op(req_data));
      end
      pending_results = owed_rsp_q.size();
   end

   always @(posedge run_done) begin
      if (owed_rsp_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", owed_rsp_q.size()));
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for array_list_position_ops_core
// Drives a directed run over the empty, boundary and out-of-range cases,
// then random phases that grow the list to full, shrink it to empty and
// mix all operations, with random idle bursts on the request side in all
// but the last phase. The checker beside the core predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
   import alpo_pkg::*;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    run_done   = 1'b0;
   logic    idling_on  = 1'b1;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_results;
   int      entry_total;

   always #2 clock = ~clock;

   array_list_position_ops_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   alpo_list_checker list_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_data        (rsp_data),
      .run_done        (run_done),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .entry_total     (entry_total)
   );

   task automatic send_item(input op_type op, input logic [7:0] pos,
                            input logic [31:0] item);
      req_type r;
      r.op   = op;
      r.pos  = pos;
      r.item = item;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_cycles(input int n);
      logic [63:0]                raw;
      logic [$bits(req_type)-1:0] noise;
      for (int i = 0; i < n; i++) begin
         raw   = {$urandom, $urandom};
         noise = raw[$bits(req_type)-1:0];
         @(negedge clock);
         start    <= 1'b0;
         req_data <= req_type'(noise);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_item();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // aim positions at the live part of the list, with some strays
   function automatic logic [7:0] pick_pos(input int span);
      case ($urandom_range(0, 9))
         0:       return 8'($urandom_range(0, 255));
         1:       return 8'(entry_total);
         2:       return 8'((entry_total == 0) ? 0 : entry_total - 1);
         default: return 8'($urandom_range(0, (span > 0) ? span - 1 : 0));
      endcase
   endfunction

   task automatic random_phase(input int n, input int grow_pct, input int shrink_pct);
      int     roll;
      op_type op;
      for (int i = 0; i < n; i++) begin
         if (idling_on && $urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 9));
         roll = $urandom_range(0, 99);
         if (roll < grow_pct) op = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_APPEND;
         else if (roll < grow_pct + shrink_pct) op = OP_DELETE;
         else op = OP_READ;
         send_item(op, pick_pos((op == OP_INSERT) ? entry_total + 1 : entry_total),
                   pick_item());
      end
   endtask

   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list and out-of-range positions
      send_item(OP_READ,   8'd0,   32'h1234_5678);
      send_item(OP_DELETE, 8'd0,   32'h0);
      send_item(OP_DELETE, 8'd255, 32'h0);
      send_item(OP_INSERT, 8'd1,   32'h5555_5555);
      send_item(OP_APPEND, 8'd255, 32'h7fff_ffff);
      send_item(OP_INSERT, 8'd0,   32'h8000_0000);
      send_item(OP_INSERT, 8'd2,   32'hffff_ffff);
      send_item(OP_INSERT, 8'd1,   32'h0000_0000);
      send_item(OP_INSERT, 8'd4,   32'ha5a5_a5a5);
      send_item(OP_INSERT, 8'd6,   32'h5a5a_5a5a);
      for (int p = 0; p < 5; p++) send_item(OP_READ, 8'(p), 32'h0);
      send_item(OP_READ,   8'd5,   32'h0);
      send_item(OP_READ,   8'd255, 32'hffff_ffff);
      send_item(OP_DELETE, 8'd5,   32'h0);
      send_item(OP_DELETE, 8'd4,   32'h0);
      send_item(OP_DELETE, 8'd0,   32'h0);
      send_item(OP_DELETE, 8'd1,   32'h0);
      send_item(OP_READ,   8'd0,   32'h0);
      send_item(OP_READ,   8'd1,   32'h0);
      send_item(OP_APPEND, 8'd17,  32'h0f0f_0f0f);
      drain_results();

      // fill past capacity, empty again, then mix
      random_phase(220, 80, 10);
      drain_results();
      random_phase(230, 10, 70);
      drain_results();
      random_phase(250, 40, 35);
      drain_results();
      random_phase(150, 75, 15);
      idling_on = 1'b0;
      random_phase(100, 40, 35);

      drain_results();
      repeat (CAPACITY + 8) @(posedge clock);
      @(negedge clock);
      run_done <= 1'b1;
      @(posedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/alpo_pkg.sv
hdl/alpo_cell.sv
hdl/array_list_position_ops_core.sv
sim/alpo_list_checker.sv
sim/tb_top.sv
